@@ hw/rtl/rotation_matrix_to_euler_assert.svh @@
// Assertion shorthands for the rotation matrix to Euler block.
`ifndef ROTATION_MATRIX_TO_EULER_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RME_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rme check failed");

// Next-cycle implication, checked out of reset.
`define RME_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rme check failed");

`endif

@@ hw/rtl/rme_pkg.sv @@
package rme_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int TAB_LEN      = 24;
    localparam int N_STEPS      = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

    localparam int OPND_W = 17;   // atan2 operands, room for a negated -2.0 word
    localparam int CORD_W = 32;   // scaled vector inside the rotator
    localparam int ACC_W  = 34;   // Q28 angle accumulator

    localparam int SQRT_ITERS = 15;
    localparam int SQRT_LAT   = SQRT_ITERS + 1;
    localparam int CORDIC_LAT = N_STEPS + 2;

    localparam logic signed [ACC_W-1:0] PI_Q28      = ACC_W'(843314857);
    localparam logic signed [15:0]      PI_Q12      = 16'sd12868;
    localparam logic signed [15:0]      HALF_PI_Q12 = 16'sd6434;
    localparam logic signed [15:0]      ONE_Q14     = 16'sd16384;

    localparam logic [0:0] REG_GIMBAL_EPS = 1'b0;

    typedef enum logic [1:0] {
        KIND_GEN1     = 2'd0,
        KIND_GEN2     = 2'd1,
        KIND_LOCK_NEG = 2'd2,
        KIND_LOCK_POS = 2'd3
    } kind_t;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_z;
        logic signed [15:0] back_x;
        logic signed [15:0] back_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        kind_t              solution_kind;
    } out_t;

    function automatic logic signed [ACC_W-1:0] atan_q28(input int i);
        logic signed [ACC_W-1:0] r;
        unique case (i)
            0:  r = ACC_W'(210828714);
            1:  r = ACC_W'(124459457);
            2:  r = ACC_W'(65760959);
            3:  r = ACC_W'(33381290);
            4:  r = ACC_W'(16755422);
            5:  r = ACC_W'(8385879);
            6:  r = ACC_W'(4193963);
            7:  r = ACC_W'(2097109);
            8:  r = ACC_W'(1048571);
            9:  r = ACC_W'(524287);
            10: r = ACC_W'(262144);
            11: r = ACC_W'(131072);
            12: r = ACC_W'(65536);
            13: r = ACC_W'(32768);
            14: r = ACC_W'(16384);
            15: r = ACC_W'(8192);
            16: r = ACC_W'(4096);
            17: r = ACC_W'(2048);
            18: r = ACC_W'(1024);
            19: r = ACC_W'(512);
            20: r = ACC_W'(256);
            21: r = ACC_W'(128);
            22: r = ACC_W'(64);
            23: r = ACC_W'(32);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/rme_isqrt.sv @@
module rme_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [28:0] sq_in,
    output logic [14:0] root_out
);
    import rme_pkg::*;

    logic [28:0] n_reg    [0:SQRT_ITERS];
    logic [29:0] root_reg [0:SQRT_ITERS];

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]    <= 29'h1000_0000 - sq_in;
            root_reg[0] <= '0;
            // one result bit per stage, trial bit walks down by two places
            for (int j = 0; j < SQRT_ITERS; j++) begin
                if ({1'b0, n_reg[j]} >= root_reg[j] + (30'd1 << (28 - 2 * j))) begin
                    n_reg[j+1]    <= 29'({1'b0, n_reg[j]} - root_reg[j]
                                         - (30'd1 << (28 - 2 * j)));
                    root_reg[j+1] <= (root_reg[j] >> 1) + (30'd1 << (28 - 2 * j));
                end else begin
                    n_reg[j+1]    <= n_reg[j];
                    root_reg[j+1] <= root_reg[j] >> 1;
                end
            end
        end
    end

    assign root_out = root_reg[SQRT_ITERS][14:0];

endmodule

@@ hw/rtl/rme_cordic.sv @@
module rme_cordic (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [rme_pkg::OPND_W-1:0]  y_in,
    input  logic signed [rme_pkg::OPND_W-1:0]  x_in,
    output logic signed [15:0]                 angle
);
    import rme_pkg::*;

    logic signed [CORD_W-1:0] x_reg    [0:N_STEPS];
    logic signed [CORD_W-1:0] y_reg    [0:N_STEPS];
    logic signed [ACC_W-1:0]  acc_reg  [0:N_STEPS];
    logic                     zero_reg [0:N_STEPS];
    logic signed [15:0]       angle_reg;

    logic signed [CORD_W-1:0] x_pre, y_pre;
    logic signed [ACC_W-1:0]  acc_pre, acc_rnd;

    always_comb begin
        x_pre   = CORD_W'(x_in) <<< 10;
        y_pre   = CORD_W'(y_in) <<< 10;
        acc_pre = '0;
        // left half plane: turn by pi first
        if (x_in < 0) begin
            acc_pre = (y_in >= 0) ? PI_Q28 : -PI_Q28;
            x_pre   = -x_pre;
            y_pre   = -y_pre;
        end
    end

    assign acc_rnd = (acc_reg[N_STEPS] + ACC_W'(32768)) >>> 16;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x_pre;
            y_reg[0]    <= y_pre;
            acc_reg[0]  <= acc_pre;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
            for (int k = 0; k < N_STEPS; k++) begin
                zero_reg[k+1] <= zero_reg[k];
                if (y_reg[k] > 0) begin
                    x_reg[k+1]   <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1]   <= y_reg[k] - (x_reg[k] >>> k);
                    acc_reg[k+1] <= acc_reg[k] + atan_q28(k);
                end else begin
                    x_reg[k+1]   <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1]   <= y_reg[k] + (x_reg[k] >>> k);
                    acc_reg[k+1] <= acc_reg[k] - atan_q28(k);
                end
            end
            angle_reg <= zero_reg[N_STEPS] ? '0 : acc_rnd[15:0];
        end
    end

    assign angle = angle_reg;

endmodule

@@ hw/rtl/rotation_matrix_to_euler.sv @@
// Rotation matrix (Q2.14 right, up and back rows) to X, Y, Z Euler angles in
// Q4.12 radians, with gimbal-lock detection against the gimbal_epsilon register
// (APB offset 0x0, reset 1). Fully pipelined: one word per cycle while the result
// side is not stalled, through the 16-stage square-root pipeline followed by the
// unrolled CORDIC rotators. A stall on the result side freezes the whole
// pipeline in place.
module rotation_matrix_to_euler (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rme_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rme_pkg::out_t  m_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import rme_pkg::*;

    localparam int LAT_ALL = 2 + SQRT_LAT + CORDIC_LAT + 2;

    typedef struct packed {
        logic signed [15:0]       s;
        kind_t                    kind;
        logic signed [OPND_W-1:0] z1y, z1x, z2y, z2x, x1y, x1x, x2y, x2x;
    } side_t;

    logic        en;
    logic [10:0] eps_reg;
    logic        vld_reg [0:LAT_ALL-1];

    // stage A
    in_t a_reg;
    // stage B
    side_t       b_next, b_reg;
    logic [28:0] sq_next, sq_reg;
    // sqrt and cordic alignment
    side_t       side_reg [0:SQRT_LAT-1];
    kind_t       kd_reg   [0:CORDIC_LAT-1];
    logic [14:0] root;
    logic signed [15:0] ang_y, ang_x1, ang_x2, ang_z1, ang_z2;
    // stage D
    logic signed [15:0] x1_reg, x2_reg, z1_reg, z2_reg;
    logic signed [16:0] y1_reg;
    logic signed [17:0] y2_reg;
    logic [17:0]        sum1_reg, sum2_reg;
    kind_t              kd_d_reg;
    logic signed [16:0] y1_next;
    logic signed [17:0] y2_next;
    // stage E
    out_t out_reg, out_next;

    assign en      = !vld_reg[LAT_ALL-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT_ALL-1];
    assign m_data  = out_reg;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GIMBAL_EPS) ? {21'd0, eps_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= 11'd1;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_GIMBAL_EPS) begin
            eps_reg <= pwdata[10:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT_ALL; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < LAT_ALL; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    function automatic logic signed [OPND_W-1:0] neg17(input logic signed [15:0] v);
        return -(OPND_W'(v));
    endfunction

    // stage B: lock test, saturated sine, operand setup
    always_comb begin
        logic signed [16:0] dn, dp;
        logic [16:0]        an, ap;
        logic signed [15:0] s;
        logic signed [31:0] prod;
        dn = 17'(a_reg.right_z) + 17'(ONE_Q14);
        dp = 17'(a_reg.right_z) - 17'(ONE_Q14);
        an = (dn < 0) ? 17'(-dn) : 17'(dn);
        ap = (dp < 0) ? 17'(-dp) : 17'(dp);
        s  = a_reg.right_z;
        if (s > ONE_Q14)  s = ONE_Q14;
        if (s < -ONE_Q14) s = -ONE_Q14;
        prod = s * s;
        sq_next = prod[28:0];

        b_next.s   = s;
        b_next.x1y = OPND_W'(a_reg.up_z);
        b_next.x1x = OPND_W'(a_reg.back_z);
        b_next.x2y = neg17(a_reg.up_z);
        b_next.x2x = neg17(a_reg.back_z);
        b_next.z2y = neg17(a_reg.right_y);
        b_next.z2x = neg17(a_reg.right_x);
        if ({6'd0, eps_reg} > an) begin
            b_next.kind = KIND_LOCK_NEG;
            b_next.z1y  = OPND_W'(a_reg.up_x);
            b_next.z1x  = OPND_W'(a_reg.back_x);
        end else if ({6'd0, eps_reg} > ap) begin
            b_next.kind = KIND_LOCK_POS;
            b_next.z1y  = neg17(a_reg.up_x);
            b_next.z1x  = neg17(a_reg.back_x);
        end else begin
            b_next.kind = KIND_GEN1;
            b_next.z1y  = OPND_W'(a_reg.right_y);
            b_next.z1x  = OPND_W'(a_reg.right_x);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= s_data;
            b_reg  <= b_next;
            sq_reg <= sq_next;
            side_reg[0] <= b_reg;
            for (int i = 1; i < SQRT_LAT; i++) side_reg[i] <= side_reg[i-1];
            kd_reg[0] <= side_reg[SQRT_LAT-1].kind;
            for (int i = 1; i < CORDIC_LAT; i++) kd_reg[i] <= kd_reg[i-1];
        end
    end

    rme_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .sq_in    (sq_reg),
        .root_out (root)
    );

    rme_cordic u_cordic_y (
        .aclk (aclk), .en (en),
        .y_in (OPND_W'(side_reg[SQRT_LAT-1].s)),
        .x_in ({2'b00, root}),
        .angle(ang_y)
    );
    rme_cordic u_cordic_x1 (
        .aclk (aclk), .en (en),
        .y_in (side_reg[SQRT_LAT-1].x1y), .x_in (side_reg[SQRT_LAT-1].x1x),
        .angle(ang_x1)
    );
    rme_cordic u_cordic_x2 (
        .aclk (aclk), .en (en),
        .y_in (side_reg[SQRT_LAT-1].x2y), .x_in (side_reg[SQRT_LAT-1].x2x),
        .angle(ang_x2)
    );
    rme_cordic u_cordic_z1 (
        .aclk (aclk), .en (en),
        .y_in (side_reg[SQRT_LAT-1].z1y), .x_in (side_reg[SQRT_LAT-1].z1x),
        .angle(ang_z1)
    );
    rme_cordic u_cordic_z2 (
        .aclk (aclk), .en (en),
        .y_in (side_reg[SQRT_LAT-1].z2y), .x_in (side_reg[SQRT_LAT-1].z2x),
        .angle(ang_z2)
    );

    function automatic logic [17:0] abs18(input logic signed [17:0] v);
        return (v < 0) ? 18'(-v) : 18'(v);
    endfunction

    // stage D: both general solutions and their cost
    assign y1_next = -(17'(ang_y));
    assign y2_next = 18'(PI_Q12) - 18'(y1_next);

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg   <= ang_x1;
            x2_reg   <= ang_x2;
            z1_reg   <= ang_z1;
            z2_reg   <= ang_z2;
            y1_reg   <= y1_next;
            y2_reg   <= y2_next;
            kd_d_reg <= kd_reg[CORDIC_LAT-1];
            sum1_reg <= abs18(18'(ang_x1)) + abs18(18'(y1_next)) + abs18(18'(ang_z1));
            sum2_reg <= abs18(18'(ang_x2)) + abs18(y2_next) + abs18(18'(ang_z2));
        end
    end

    // stage E: pick the solution, first one wins a tie
    always_comb begin
        out_next.angle_z = z1_reg;
        unique case (kd_d_reg)
            KIND_LOCK_NEG: begin
                out_next.angle_x       = '0;
                out_next.angle_y       = HALF_PI_Q12;
                out_next.solution_kind = KIND_LOCK_NEG;
            end
            KIND_LOCK_POS: begin
                out_next.angle_x       = '0;
                out_next.angle_y       = -HALF_PI_Q12;
                out_next.solution_kind = KIND_LOCK_POS;
            end
            default: begin
                if (sum1_reg <= sum2_reg) begin
                    out_next.angle_x       = x1_reg;
                    out_next.angle_y       = y1_reg[15:0];
                    out_next.solution_kind = KIND_GEN1;
                end else begin
                    out_next.angle_x       = x2_reg;
                    out_next.angle_y       = y2_reg[15:0];
                    out_next.angle_z       = z2_reg;
                    out_next.solution_kind = KIND_GEN2;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

`include "rotation_matrix_to_euler_assert.svh"

    `RME_ASSERT_NOW(a_lock_x_zero, aclk, aresetn,
        m_valid && m_data.solution_kind[1], m_data.angle_x == 16'sd0)
    `RME_ASSERT_NOW(a_lock_neg_y, aclk, aresetn,
        m_valid && m_data.solution_kind == KIND_LOCK_NEG, m_data.angle_y == HALF_PI_Q12)
    `RME_ASSERT_NOW(a_lock_pos_y, aclk, aresetn,
        m_valid && m_data.solution_kind == KIND_LOCK_POS, m_data.angle_y == -HALF_PI_Q12)
    `RME_ASSERT_NEXT(a_eps_write, aclk, aresetn,
        psel && penable && pwrite && paddr[2] == REG_GIMBAL_EPS,
        eps_reg == $past(pwdata[10:0]))

endmodule
